// ----- rtl/core/tmpb_pkg.sv -----
// Package of the transparency mask plane builder.
// It holds the shared widths, the register index codes and the byte job passed
// from the front end to the write sequencer. It depends on nothing else.
package tmpb_pkg;

    // Widths of the stream fields and of the internal counters.
    localparam int PixelBits = 8;
    localparam int AddrBits  = 16;
    localparam int ByteBits  = 8;
    localparam int DimBits   = 11;
    localparam int ColBits   = 10;
    localparam int PlaneBits = 4;
    localparam int PlaneIdxBits = 3;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 11;

    // Clamp limits for the image geometry and plane depth.
    localparam logic [DimBits-1:0]   MaxWidth  = 11'd1024;
    localparam logic [DimBits-1:0]   MaxHeight = 11'd1024;
    localparam logic [PlaneBits-1:0] MaxPlanes = 4'd8;

    // Depth of the job queue between front end and sequencer.
    localparam int QueueDepth = 4;
    localparam int QueuePtrBits = 2;
    localparam int QueueCntBits = 3;

    // Register index codes of the configuration port.
    typedef enum logic [CfgIdxBits-1:0] {
        CFG_TRANSPARENT_COLOR = 3'd0,
        CFG_IMAGE_WIDTH       = 3'd1,
        CFG_IMAGE_HEIGHT      = 3'd2,
        CFG_PLANE_COUNT       = 3'd3,
        CFG_PLANE_ROW_BYTES   = 3'd4,
        CFG_INTERLEAVED       = 3'd5
    } cfg_index_t;

    // One completed mask byte and how to replicate it over the planes.
    typedef struct packed {
        logic [AddrBits-1:0]     addr;
        logic [ByteBits-1:0]     data;
        logic [PlaneIdxBits-1:0] last_plane;
        logic [ByteBits-1:0]     step;
        logic                    img_end;
    } job_t;

endpackage

// ----- rtl/core/tmpb_front.sv -----
// Front end of the mask builder: configuration registers, raster position
// tracking and mask bit packing. Each finished byte is handed out as a job.
// Depends on tmpb_pkg.
module tmpb_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tmpb_pkg::CfgIdxBits-1:0]   cfg_index,
    input  logic [tmpb_pkg::CfgDataBits-1:0]  cfg_wdata,
    input  logic                              pix_fire,
    input  logic [tmpb_pkg::PixelBits-1:0]    pix_color,
    output logic                              job_push,
    output tmpb_pkg::job_t                    job
);

    logic [tmpb_pkg::PixelBits-1:0] transparent_reg;
    logic [tmpb_pkg::DimBits-1:0]   width_reg;
    logic [tmpb_pkg::DimBits-1:0]   height_reg;
    logic [tmpb_pkg::PlaneBits-1:0] planes_reg;
    logic [tmpb_pkg::ByteBits-1:0]  row_bytes_reg;
    logic                           interleaved_reg;

    logic [tmpb_pkg::ColBits-1:0]   column_reg, column_next;
    logic [tmpb_pkg::ColBits-1:0]   row_reg, row_next;
    logic [2:0]                     bitpos_reg, bitpos_next;
    logic [tmpb_pkg::ByteBits-1:0]  acc_reg, acc_next;
    logic [tmpb_pkg::AddrBits-1:0]  baddr_reg, baddr_next;

    logic [tmpb_pkg::DimBits-1:0]      width_eff;
    logic [tmpb_pkg::DimBits-1:0]      height_eff;
    logic [tmpb_pkg::PlaneBits-1:0]    planes_eff;
    logic [tmpb_pkg::PlaneIdxBits-1:0] last_plane;
    logic [tmpb_pkg::DimBits-1:0]      stride;
    logic [tmpb_pkg::ByteBits-1:0]     acc_set;
    logic                              byte_done;
    logic                              row_end;
    logic                              img_end;
    logic [tmpb_pkg::AddrBits-1:0]     baddr_inc;

    // Configuration registers, written one at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transparent_reg <= '0;
            width_reg       <= 11'd8;
            height_reg      <= 11'd1;
            planes_reg      <= 4'd1;
            row_bytes_reg   <= 8'd1;
            interleaved_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tmpb_pkg::CFG_TRANSPARENT_COLOR: transparent_reg <= cfg_wdata[7:0];
                tmpb_pkg::CFG_IMAGE_WIDTH:       width_reg       <= cfg_wdata;
                tmpb_pkg::CFG_IMAGE_HEIGHT:      height_reg      <= cfg_wdata;
                tmpb_pkg::CFG_PLANE_COUNT:       planes_reg      <= cfg_wdata[3:0];
                tmpb_pkg::CFG_PLANE_ROW_BYTES:   row_bytes_reg   <= cfg_wdata[7:0];
                tmpb_pkg::CFG_INTERLEAVED:       interleaved_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Effective geometry: zero counts act as one, large ones saturate.
    always_comb begin
        if (width_reg == '0)
            width_eff = 11'd1;
        else if (width_reg > tmpb_pkg::MaxWidth)
            width_eff = tmpb_pkg::MaxWidth;
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = 11'd1;
        else if (height_reg > tmpb_pkg::MaxHeight)
            height_eff = tmpb_pkg::MaxHeight;
        else
            height_eff = height_reg;

        if (planes_reg == '0)
            planes_eff = 4'd1;
        else if (planes_reg > tmpb_pkg::MaxPlanes)
            planes_eff = tmpb_pkg::MaxPlanes;
        else
            planes_eff = planes_reg;
    end

    // Plane replication count and the row skip over the other planes.
    logic [tmpb_pkg::PlaneBits-1:0] planes_m1;
    assign planes_m1  = planes_eff - 4'd1;
    assign last_plane = interleaved_reg ? planes_m1[2:0] : 3'd0;
    assign stride     = interleaved_reg ? (11'(row_bytes_reg) * 11'(planes_m1[2:0])) : '0;

    // Position flags and the accumulator with this pixel's bit merged in.
    assign row_end   = (11'(column_reg) + 11'd1) >= width_eff;
    assign img_end   = row_end && ((11'(row_reg) + 11'd1) >= height_eff);
    assign byte_done = (bitpos_reg == 3'd0);
    assign acc_set   = acc_reg |
                       ((pix_color != transparent_reg) ? (8'd1 << bitpos_reg) : 8'd0);
    assign baddr_inc = baddr_reg + (byte_done ? 16'd1 : 16'd0);

    // Next raster position, bit slot and byte address.
    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        bitpos_next = bitpos_reg;
        acc_next    = acc_reg;
        baddr_next  = baddr_reg;
        if (pix_fire) begin
            if (row_end) begin
                column_next = '0;
                bitpos_next = 3'd7;
                acc_next    = '0;
                if (img_end) begin
                    row_next   = '0;
                    baddr_next = '0;
                end else begin
                    row_next   = row_reg + 10'd1;
                    baddr_next = baddr_inc + 16'(stride);
                end
            end else begin
                column_next = column_reg + 10'd1;
                baddr_next  = baddr_inc;
                if (byte_done) begin
                    bitpos_next = 3'd7;
                    acc_next    = '0;
                end else begin
                    bitpos_next = bitpos_reg - 3'd1;
                    acc_next    = acc_set;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
            bitpos_reg <= 3'd7;
            acc_reg    <= '0;
            baddr_reg  <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
            bitpos_reg <= bitpos_next;
            acc_reg    <= acc_next;
            baddr_reg  <= baddr_next;
        end
    end

    // A job leaves with every pixel that fills the last bit slot of a byte.
    assign job_push        = pix_fire && byte_done;
    assign job.addr        = baddr_reg;
    assign job.data        = acc_set;
    assign job.last_plane  = last_plane;
    assign job.step        = row_bytes_reg;
    assign job.img_end     = img_end;

endmodule

// ----- rtl/core/tmpb_queue.sv -----
// Short job queue between the front end and the write sequencer.
// A small register array with read and write pointers. Depends on tmpb_pkg.
module tmpb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tmpb_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tmpb_pkg::job_t head_job
);

    tmpb_pkg::job_t mem_reg [tmpb_pkg::QueueDepth];
    logic [tmpb_pkg::QueuePtrBits-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tmpb_pkg::QueueCntBits-1:0] count_reg;
    logic do_push, do_pop;

    assign full      = (count_reg == tmpb_pkg::QueueCntBits'(tmpb_pkg::QueueDepth));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_job  = mem_reg[rd_ptr_reg];

    // Storage needs no reset; only the entries between the pointers are read.
    always_ff @(posedge aclk) begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 3'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 3'd1;
        end
    end

endmodule

// ----- rtl/core/tmpb_back.sv -----
// Write sequencer of the mask builder: expands each byte job into one write
// per plane copy, driven from registers. Depends on tmpb_pkg.
module tmpb_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_avail,
    input  tmpb_pkg::job_t                 job,
    output logic                           job_pop,
    output logic                           wr_valid,
    input  logic                           wr_ready,
    output logic [tmpb_pkg::AddrBits-1:0]  wr_addr,
    output logic [tmpb_pkg::ByteBits-1:0]  wr_byte,
    output logic                           wr_last,
    output logic                           wr_done
);

    logic                              busy_reg, busy_next;
    logic [tmpb_pkg::AddrBits-1:0]     addr_reg, addr_next;
    logic [tmpb_pkg::ByteBits-1:0]     data_reg, data_next;
    logic [tmpb_pkg::PlaneIdxBits-1:0] plane_reg, plane_next;
    logic [tmpb_pkg::PlaneIdxBits-1:0] last_plane_reg, last_plane_next;
    logic [tmpb_pkg::ByteBits-1:0]     step_reg, step_next;
    logic                              img_end_reg, img_end_next;
    logic                              is_last;
    logic                              wr_fire;

    assign is_last = (plane_reg == last_plane_reg);
    assign wr_fire = busy_reg && wr_ready;
    assign job_pop = job_avail && (!busy_reg || (wr_fire && is_last));

    // Advance over the plane copies, loading the next job after the last one.
    always_comb begin
        busy_next       = busy_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        plane_next      = plane_reg;
        last_plane_next = last_plane_reg;
        step_next       = step_reg;
        img_end_next    = img_end_reg;
        if (job_pop) begin
            busy_next       = 1'b1;
            addr_next       = job.addr;
            data_next       = job.data;
            plane_next      = '0;
            last_plane_next = job.last_plane;
            step_next       = job.step;
            img_end_next    = job.img_end;
        end else if (wr_fire) begin
            if (is_last) begin
                busy_next = 1'b0;
            end else begin
                addr_next  = addr_reg + 16'(step_reg);
                plane_next = plane_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        plane_reg      <= plane_next;
        last_plane_reg <= last_plane_next;
        step_reg       <= step_next;
        img_end_reg    <= img_end_next;
    end

    assign wr_valid = busy_reg;
    assign wr_addr  = addr_reg;
    assign wr_byte  = data_reg;
    assign wr_last  = is_last;
    assign wr_done  = is_last && img_end_reg;

endmodule

// ----- rtl/core/transparency_mask_plane_builder_top.sv -----
// Top level of the transparency mask plane builder.
// Instantiates tmpb_front, tmpb_queue and tmpb_back; depends on tmpb_pkg.
//
//  channel  | direction | tdata (low bit up)                    | side band
//  s_axis   | in        | pixel_color[7:0]                      | none
//  m_axis   | out       | write_address[15:0], write_byte[7:0]  | tlast last_write,
//           |           |                                       | tuser image_done
//  cfg      | in        | cfg_wdata per register, cfg_index     | cfg_wr_en
//
// One pixel is accepted per cycle while the four-entry job queue has room.
// Each completed byte leaves as one write per plane copy (one copy, or plane_count copies,
// clamped to 1..8, in interleaved mode), one per cycle while m_tready is high, paced by the
// sequencer. Sustained rate is one pixel per cycle while the copies per byte stay at or
// below eight and m_tready is high; each byte's job is registered in the queue and then
// in the sequencer before its first write leaves. Synchronous active-low reset clears all
// control state; m_tready stalls only the sequencer until the queue fills, then s_tready drops.
module transparency_mask_plane_builder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [tmpb_pkg::CfgIdxBits-1:0]   cfg_index,
    input  logic [tmpb_pkg::CfgDataBits-1:0]  cfg_wdata,
    // Pixel stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // pixel_color[7:0]
    // Mask write stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,  // write_address[15:0], write_byte[23:16]
    output logic                              m_tlast,  // last_write
    output logic                              m_tuser   // image_done
);

    logic           pix_fire;
    logic           job_push;
    tmpb_pkg::job_t push_job;
    logic           queue_full;
    logic           queue_pop;
    logic           queue_avail;
    tmpb_pkg::job_t head_job;
    logic [tmpb_pkg::AddrBits-1:0] wr_addr;
    logic [tmpb_pkg::ByteBits-1:0] wr_byte;

    assign s_tready = !queue_full;
    assign pix_fire = s_tvalid && s_tready;

    // Front end: position tracking and bit packing.
    tmpb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pix_fire  (pix_fire),
        .pix_color (s_tdata),
        .job_push  (job_push),
        .job       (push_job)
    );

    // Byte jobs waiting for the sequencer.
    tmpb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_avail),
        .head_job  (head_job)
    );

    // Sequencer: plane copies of each byte.
    tmpb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_avail (queue_avail),
        .job       (head_job),
        .job_pop   (queue_pop),
        .wr_valid  (m_tvalid),
        .wr_ready  (m_tready),
        .wr_addr   (wr_addr),
        .wr_byte   (wr_byte),
        .wr_last   (m_tlast),
        .wr_done   (m_tuser)
    );

    assign m_tdata = {wr_byte, wr_addr};

endmodule

// ----- verif/testbench.sv -----
// Self-checking bench for transparency_mask_plane_builder_top: pixels in, mask byte writes out.
// Holds its own mask-packing predictor, a directed table and random phases with stalls.
// Depends on tmpb_pkg and the RTL top level only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tmpb_pkg::*;

    localparam int QuietLimit = 1000;
    localparam int SettleCycles = 8;
    localparam int RandomPixels = 260;
    localparam int ReportLimit = 10;

    // One mask memory write as it leaves the block.
    typedef struct packed {
        logic [AddrBits-1:0] addr;
        logic [ByteBits-1:0] mask;
        logic                last;
        logic                done;
    } mask_write_t;

    typedef enum logic {
        STEP_PIXEL,
        STEP_CONFIG
    } step_kind_t;

    // A row of the directed table: a pixel or a register write.
    typedef struct packed {
        step_kind_t          kind;
        cfg_index_t          index;
        logic [10:0]         value;
        logic                typed;
        mask_write_t         want;
    } step_t;

    localparam int DirectedSteps = 23;

    // After reset: one 8-pixel image, then an interleaved row that drops its ninth bit.
    localparam step_t DIRECTED [DirectedSteps] = '{
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd1,    1'b1,
          '{16'h0000, 8'h81, 1'b1, 1'b1}},
        '{STEP_CONFIG, CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_CONFIG, CFG_IMAGE_WIDTH,       11'd9,    1'b0, '0},
        '{STEP_CONFIG, CFG_IMAGE_HEIGHT,      11'd0,    1'b0, '0},
        '{STEP_CONFIG, CFG_PLANE_COUNT,       11'd15,   1'b0, '0},
        '{STEP_CONFIG, CFG_PLANE_ROW_BYTES,   11'd0,    1'b0, '0},
        '{STEP_CONFIG, CFG_INTERLEAVED,       11'd1,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd255,  1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd0,    1'b0, '0},
        '{STEP_PIXEL,  CFG_TRANSPARENT_COLOR, 11'd128,  1'b0, '0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CfgIdxBits-1:0]  cfg_index = '0;
    logic [CfgDataBits-1:0] cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;

    // Predictor copy of the registers.
    logic [7:0]  cfg_key = 8'd0;
    logic [10:0] cfg_width = 11'd8;
    logic [10:0] cfg_height = 11'd1;
    logic [3:0]  cfg_planes = 4'd1;
    logic [7:0]  cfg_row_bytes = 8'd1;
    logic        cfg_interleaved = 1'b0;

    // Predictor copy of the raster and packing state.
    logic [9:0]  col_pos = '0;
    logic [9:0]  row_pos = '0;
    logic [2:0]  bit_pos = 3'd7;
    logic [7:0]  mask_acc = '0;
    logic [15:0] byte_addr = '0;

    mask_write_t pending_writes[$];
    mask_write_t fresh_writes[$];
    int          errors = 0;
    int          pixels_sent = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 30;
    int          take_stall_pct = 30;
    int          stall_left = 0;

    transparency_mask_plane_builder_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Zero counts as one, anything above the limit as the limit.
    function automatic logic [10:0] clamp_dim(input logic [10:0] v, input logic [10:0] hi);
        if (v == 11'd0) return 11'd1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Packs one pixel into the mask byte and lists the plane writes it completes.
    function automatic void predict_mask_writes(input logic [7:0] color);
        logic [10:0] w;
        logic [10:0] h;
        logic [10:0] d;
        logic [15:0] stride;
        logic [15:0] addr;
        logic        row_done;
        logic        image_over;
        int          copies;
        w = clamp_dim(cfg_width, MaxWidth);
        h = clamp_dim(cfg_height, MaxHeight);
        d = clamp_dim({7'd0, cfg_planes}, {7'd0, MaxPlanes});
        copies = cfg_interleaved ? int'(d) : 1;
        stride = cfg_interleaved ? 16'(cfg_row_bytes) * 16'(d - 11'd1) : 16'd0;
        row_done = ({1'b0, col_pos} + 11'd1 >= w);
        image_over = row_done && ({1'b0, row_pos} + 11'd1 >= h);
        fresh_writes.delete();

        if (color != cfg_key) mask_acc[bit_pos] = 1'b1;

        // A full byte goes out once per plane copy.
        if (bit_pos == 3'd0) begin
            addr = byte_addr;
            for (int p = 0; p < copies; p++) begin
                fresh_writes.push_back('{addr, mask_acc, p == copies - 1,
                                         (p == copies - 1) && image_over});
                addr = addr + 16'(cfg_row_bytes);
            end
            byte_addr = byte_addr + 16'd1;
            bit_pos = 3'd7;
            mask_acc = 8'd0;
        end else begin
            bit_pos = bit_pos - 3'd1;
        end

        // Row end drops the partial byte; image end rewinds to address zero.
        if (row_done) begin
            col_pos = '0;
            bit_pos = 3'd7;
            mask_acc = 8'd0;
            if (image_over) begin
                row_pos = '0;
                byte_addr = 16'd0;
            end else begin
                row_pos = row_pos + 10'd1;
                byte_addr = byte_addr + stride;
            end
        end else begin
            col_pos = col_pos + 10'd1;
        end
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len(input int pct);
        if ($urandom_range(99) < pct) begin
            if ($urandom_range(9) == 0) return $urandom_range(30, 8);
            return $urandom_range(3, 1);
        end
        return 0;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 15;
            default: return 50;
        endcase
    endfunction

    // Register values biased toward the clamp limits and the byte boundaries.
    function automatic logic [10:0] random_setting(input cfg_index_t idx);
        case (idx)
            CFG_TRANSPARENT_COLOR: return 11'($urandom_range(255));
            CFG_IMAGE_WIDTH: begin
                case ($urandom_range(7))
                    0: return 11'd0;
                    1: return 11'($urandom_range(7, 1));
                    2: return 11'd8;
                    3: return 11'd16;
                    4: return 11'($urandom_range(40, 9));
                    5: return 11'd1024;
                    6: return 11'($urandom_range(2047, 1025));
                    default: return 11'd24;
                endcase
            end
            CFG_IMAGE_HEIGHT: begin
                case ($urandom_range(5))
                    0: return 11'd0;
                    1: return 11'd1024;
                    2: return 11'($urandom_range(2047, 1025));
                    default: return 11'($urandom_range(6, 1));
                endcase
            end
            CFG_PLANE_COUNT: return 11'($urandom_range(15));
            CFG_PLANE_ROW_BYTES: begin
                case ($urandom_range(3))
                    0: return 11'd0;
                    1: return 11'd255;
                    default: return 11'($urandom_range(254, 1));
                endcase
            end
            default: return 11'($urandom_range(1));
        endcase
    endfunction

    function automatic logic [7:0] random_pixel();
        if ($urandom_range(1)) return cfg_key;
        return 8'($urandom_range(255));
    endfunction

    // Lowers the pixel stream and waits until every write is back and the pipe is quiet.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [10:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_TRANSPARENT_COLOR: cfg_key = value[7:0];
            CFG_IMAGE_WIDTH:       cfg_width = value;
            CFG_IMAGE_HEIGHT:      cfg_height = value;
            CFG_PLANE_COUNT:       cfg_planes = value[3:0];
            CFG_PLANE_ROW_BYTES:   cfg_row_bytes = value[7:0];
            CFG_INTERLEAVED:       cfg_interleaved = value[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Sends one pixel; tvalid stays high afterwards so back-to-back items need no dip.
    task automatic push_pixel(input logic [7:0] color, input logic typed,
                              input mask_write_t typed_write);
        int gap;
        gap = idle_len(send_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= color;
        do @(posedge aclk); while (!s_tready);
        predict_mask_writes(color);
        if (typed) begin
            pending_writes.push_back(typed_write);
        end else begin
            foreach (fresh_writes[i]) pending_writes.push_back(fresh_writes[i]);
        end
        pixels_sent++;
    endtask

    // Result side: check each accepted write, then decide the next tready.
    always @(posedge aclk) begin : take_writes
        mask_write_t got;
        mask_write_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[23:16], m_tlast, m_tuser};
            if (pending_writes.size() == 0) begin
                errors++;
                if (errors <= ReportLimit)
                    $display("unexpected write: addr %h byte %h last %b done %b",
                             got.addr, got.mask, got.last, got.done);
            end else begin
                want = pending_writes.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= ReportLimit)
                        $display("write mismatch: exp addr %h byte %h last %b done %b, got addr %h byte %h last %b done %b",
                                 want.addr, want.mask, want.last, want.done,
                                 got.addr, got.mask, got.last, got.done);
                end
            end
        end
        if (stall_left == 0) stall_left = idle_len(take_stall_pct);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int burst;
        int phase;
        int pixels_goal;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_CONFIG) begin
                wait_idle();
                write_register(DIRECTED[i].index, DIRECTED[i].value);
            end else begin
                push_pixel(DIRECTED[i].value[7:0], DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        // Random phases; the first two walk the address across the 16-bit wrap.
        pixels_goal = pixels_sent + RandomPixels;
        phase = 0;
        while (pixels_sent < pixels_goal) begin
            wait_idle();
            send_idle_pct = pick_pct();
            take_stall_pct = pick_pct();
            if (phase == 0) begin
                // One-pixel rows with the widest stride: no writes, address climbs fast.
                write_register(CFG_IMAGE_WIDTH, 11'd1);
                write_register(CFG_IMAGE_HEIGHT, 11'd1024);
                write_register(CFG_PLANE_COUNT, 11'd8);
                write_register(CFG_PLANE_ROW_BYTES, 11'd255);
                write_register(CFG_INTERLEAVED, 11'd1);
                burst = 36;
            end else if (phase == 1) begin
                // Full bytes now, with plane copies running past the top address.
                write_register(CFG_IMAGE_WIDTH, 11'd8);
                burst = 16;
            end else begin
                for (int r = 0; r <= int'(CFG_INTERLEAVED); r++) begin
                    if ($urandom_range(1))
                        write_register(cfg_index_t'(r), random_setting(cfg_index_t'(r)));
                end
                burst = $urandom_range(48, 16);
            end
            repeat (burst) push_pixel(random_pixel(), 1'b0, '0);
            phase++;
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
